### src/ps2_mouse_packet_tracker_unit_defines.svh
// ---------------------------------------------------------------------------
// ps2 mouse packet tracker assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_TRACKER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define PMPT_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define PMPT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pmpt_pkg.sv
// ---------------------------------------------------------------------------
// pmpt_pkg
// shared widths, codes and types of the ps2 mouse packet tracker
// ---------------------------------------------------------------------------
`default_nettype none

package pmpt_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 12;
    localparam int unsigned BOUND_W = 13;
    localparam int unsigned DELTA_W = 9;
    localparam int unsigned BTN_W   = 3;
    localparam int unsigned CFG_IDX_W = 1;

    // first byte layout
    localparam int unsigned SYNC_BIT   = 3;
    localparam int unsigned X_SIGN_BIT = 4;
    localparam int unsigned Y_SIGN_BIT = 5;

    localparam logic [BOUND_W-1:0] WIDTH_RST  = BOUND_W'(1024);
    localparam logic [BOUND_W-1:0] HEIGHT_RST = BOUND_W'(768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_reg;

    // position within the three-byte packet
    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_SECOND = 3'b010,
        PH_THIRD  = 3'b100
    } t_pkt_phase;

    // one axis update request
    typedef struct packed {
        logic [POS_W-1:0]   ptr;
        logic [DELTA_W-1:0] delta;
        logic               sub;
        logic [BOUND_W-1:0] bound;
    } t_axis_req;

endpackage

`default_nettype wire

### src/pmpt_byte_if.sv
// ---------------------------------------------------------------------------
// pmpt_byte_if
// channel carrying one controller byte and its auxiliary flag
// ---------------------------------------------------------------------------
`default_nettype none

interface pmpt_byte_if import pmpt_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              aux_flag;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output aux_flag, output data_byte, input ready);
    modport sink   (input valid, input aux_flag, input data_byte, output ready);

endinterface

`default_nettype wire

### src/pmpt_pos_if.sv
// ---------------------------------------------------------------------------
// pmpt_pos_if
// channel carrying pointer position and button state
// ---------------------------------------------------------------------------
`default_nettype none

interface pmpt_pos_if import pmpt_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] x_position;
    logic [POS_W-1:0] y_position;
    logic [BTN_W-1:0] button_bits;

    modport source (output valid, output x_position, output y_position,
                    output button_bits, input ready);
    modport sink   (input valid, input x_position, input y_position,
                    input button_bits, output ready);

endinterface

`default_nettype wire

### src/pmpt_axis_update.sv
// ---------------------------------------------------------------------------
// pmpt_axis_update
// adds or subtracts a nine-bit delta and clamps to zero .. bound minus one
// ---------------------------------------------------------------------------
`default_nettype none

module pmpt_axis_update import pmpt_pkg::*; (
    input  var t_axis_req        i_req,
    output logic [POS_W-1:0]     o_pos
);

    localparam int unsigned SUM_W = POS_W + 2;

    logic [SUM_W-1:0] delta_ext;
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] limit;

    // sign-extend the delta, negate for the downward axis
    assign delta_ext = {{(SUM_W-DELTA_W){i_req.delta[DELTA_W-1]}}, i_req.delta};
    assign sum = i_req.sub ? ({2'b00, i_req.ptr} - delta_ext)
                           : ({2'b00, i_req.ptr} + delta_ext);

    // zero bound acts as one, anything above 4096 saturates
    always_comb begin
        if (i_req.bound == '0) begin
            limit = '0;
        end else if (i_req.bound[BOUND_W-1]) begin
            limit = '1;
        end else begin
            limit = i_req.bound[POS_W-1:0] - POS_W'(1);
        end
    end

    always_comb begin
        if (sum[SUM_W-1]) begin
            o_pos = '0;
        end else if (sum[SUM_W-2:0] > {1'b0, limit}) begin
            o_pos = limit;
        end else begin
            o_pos = sum[POS_W-1:0];
        end
    end

endmodule

`default_nettype wire

### src/ps2_mouse_packet_tracker_unit.sv
// ---------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// gathers flagged controller bytes into mouse packets and tracks the pointer
// ---------------------------------------------------------------------------
//
//  port      dir   word                              handshake
//  i_byte    in    aux_flag, data_byte               valid / ready
//  o_pos     out   x_position, y_position, buttons   valid / ready
//  i_cfg_*   in    screen bound write (idx 0 w, 1 h) write enable only
//
//  one word accepted per cycle unless the result stalls; a word passes an
//  input register, then packet state, pointer and result slot load together
//  the pointer update is one add and one clamp compare per axis
//  i_rst_n is synchronous, active low; it clears the packet phase, pointer
//  and both valid flags and loads the default 1024 x 768 bounds
//  a stalled result holds back the input register, so every word waits
//  while the result slot is full and not taken, whether it makes a result or not
//
`default_nettype none
`include "ps2_mouse_packet_tracker_unit_defines.svh"

module ps2_mouse_packet_tracker_unit import pmpt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pmpt_byte_if.sink            i_byte,
    pmpt_pos_if.source           o_pos,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BOUND_W-1:0]   i_cfg_data
);

    // configuration
    logic [BOUND_W-1:0] r_width;
    logic [BOUND_W-1:0] r_height;

    // input register
    logic              r_in_valid;
    logic              r_in_aux;
    logic [BYTE_W-1:0] r_in_data;

    // packet state
    t_pkt_phase        r_phase,  n_phase;
    logic [BYTE_W-1:0] r_first,  n_first;
    logic [BYTE_W-1:0] r_second, n_second;
    logic [POS_W-1:0]  r_ptr_x,  n_ptr_x;
    logic [POS_W-1:0]  r_ptr_y,  n_ptr_y;

    // result register
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_x;
    logic [POS_W-1:0] r_out_y;
    logic [BTN_W-1:0] r_out_btn;

    logic             out_free;
    logic             advance;
    logic             emit;
    t_axis_req        x_req;
    t_axis_req        y_req;
    logic [POS_W-1:0] new_x;
    logic [POS_W-1:0] new_y;

    // handshake: the input register moves on whenever the result slot is free
    assign out_free     = !r_out_valid || o_pos.ready;
    assign advance      = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || advance;

    // bound writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_aux  <= i_byte.aux_flag;
            r_in_data <= i_byte.data_byte;
        end
    end

    // axis updates: x adds its delta, y subtracts (screen y grows downward)
    assign x_req = '{ptr:   r_ptr_x,
                     delta: {r_first[X_SIGN_BIT], r_second},
                     sub:   1'b0,
                     bound: r_width};
    assign y_req = '{ptr:   r_ptr_y,
                     delta: {r_first[Y_SIGN_BIT], r_in_data},
                     sub:   1'b1,
                     bound: r_height};

    pmpt_axis_update u_axis_x (
        .i_req (x_req),
        .o_pos (new_x)
    );

    pmpt_axis_update u_axis_y (
        .i_req (y_req),
        .o_pos (new_y)
    );

    // packet sequencing; a third byte whose packet lacks the sync bit is dropped
    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        n_ptr_x  = r_ptr_x;
        n_ptr_y  = r_ptr_y;
        emit     = 1'b0;
        if (advance && r_in_aux) begin
            case (r_phase)
                PH_SECOND: begin
                    n_second = r_in_data;
                    n_phase  = PH_THIRD;
                end
                PH_THIRD: begin
                    n_phase = PH_FIRST;
                    if (r_first[SYNC_BIT]) begin
                        n_ptr_x = new_x;
                        n_ptr_y = new_y;
                        emit    = 1'b1;
                    end
                end
                default: begin
                    n_first = r_in_data;
                    n_phase = PH_SECOND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_first  <= '0;
            r_second <= '0;
            r_ptr_x  <= '0;
            r_ptr_y  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
            r_ptr_x  <= n_ptr_x;
            r_ptr_y  <= n_ptr_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pos.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x   <= new_x;
            r_out_y   <= new_y;
            r_out_btn <= r_first[BTN_W-1:0];
        end
    end

    assign o_pos.valid       = r_out_valid;
    assign o_pos.x_position  = r_out_x;
    assign o_pos.y_position  = r_out_y;
    assign o_pos.button_bits = r_out_btn;

    // a completed valid packet always lands in the result slot
    `PMPT_ASSERT_NEXT(a_emit_lands, i_clk, i_rst_n, emit, r_out_valid, "packet result lost")

    // a pending result always reflects the current pointer
    `PMPT_ASSERT_IMPLIES(a_out_tracks_ptr, i_clk, i_rst_n, r_out_valid,
        (r_out_x == r_ptr_x) && (r_out_y == r_ptr_y), "result differs from pointer")

    // words without the aux flag leave the packet state alone
    `PMPT_ASSERT_NEXT(a_non_aux_ignored, i_clk, i_rst_n, advance && !r_in_aux,
        (r_phase == $past(r_phase)) && (r_ptr_x == $past(r_ptr_x)), "non-aux word changed state")

    // a packet without the sync bit moves nothing
    `PMPT_ASSERT_NEXT(a_drop_keeps_ptr, i_clk, i_rst_n,
        advance && r_in_aux && (r_phase == PH_THIRD) && !r_first[SYNC_BIT],
        (r_ptr_x == $past(r_ptr_x)) && (r_ptr_y == $past(r_ptr_y)) && (r_phase == PH_FIRST),
        "dropped packet moved pointer")

endmodule

`default_nettype wire
